// ===== hw/rtl/esud_pkg.sv =====
// Shared types and constants for the epoch seconds to UTC date converter.
// Holds reciprocal constants, month tables and the civil date result struct.
// No dependencies.
package esud_pkg;

    // Pipeline depth of the whole converter and of the calendar section.
    localparam int STAGES    = 11;
    localparam int CIVIL_LAT = 7;

    // Input is biased by 24856 days so that the day count is never negative.
    // The bias is a multiple of 128 s, so it is added to the upper input bits only.
    localparam logic [25:0] DAY_X_BIAS = 26'd16777800;

    // Reciprocals used in place of division by constants.
    localparam logic [26:0] RECIP_675  = 27'd101806632;  // 2^36 / 675, floor
    localparam logic [18:0] RECIP_60   = 19'd279621;     // 2^24 / 60, ceiling
    localparam logic [16:0] RECIP_7    = 17'd74899;      // 2^19 / 7, ceiling
    localparam logic [17:0] RECIP_1460 = 18'd183860;     // 2^28 / 1460, ceiling
    localparam logic [18:0] RECIP_365  = 19'd367720;     // 2^27 / 365, ceiling
    localparam logic [12:0] RECIP_153  = 13'd6854;       // 2^20 / 153, ceiling

    // Day split constants.
    localparam logic [10:0] DAY_REM_LIMIT = 11'd675;

    // Biased day count at which the 400-year cycle starting in 2000 begins,
    // and offsets that turn the biased day count into the day of that cycle.
    localparam logic [15:0] ERA_2000_DAY    = 16'd35873;
    localparam logic [17:0] ERA_2000_OFFSET = 18'd35873;
    localparam logic [17:0] ERA_1600_OFFSET = 18'd110224;

    // Day-of-cycle thresholds for whole centuries within a 400-year cycle.
    localparam logic [17:0] CENTURY_1_DAYS = 18'd36524;
    localparam logic [17:0] CENTURY_2_DAYS = 18'd73048;
    localparam logic [17:0] CENTURY_3_DAYS = 18'd109572;
    localparam logic [17:0] LAST_CYCLE_DAY = 18'd146096;

    // Month codes.
    localparam logic [3:0] MONTH_JANUARY = 4'd0;
    localparam logic [3:0] MONTH_MARCH_POS_LIMIT = 4'd10;

    // Day offset of each month within a year that starts on March 1.
    localparam logic [8:0] MARCH_MONTH_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    // Days before each month in a common year, January first.
    localparam logic [8:0] DAYS_BEFORE_MONTH [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [3:0] month_index;
        logic [4:0] day_of_month;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
    } civil_date_t;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
    } clock_time_t;

endpackage

// ===== hw/rtl/epoch_seconds_to_utc_date.sv =====
// Top level of the epoch seconds to UTC date converter.
// Depends on esud_pkg and esud_civil.
//
//  channel   direction  handshake              payload
//  request   in         in_valid / in_stall    epoch_seconds
//  result    out        out_valid / out_stall  second, minute, hour, day_of_month,
//                                              month_index, years_since_1900,
//                                              weekday, day_of_year
//
// Every request gives exactly one result, and a new request can enter on
// every cycle while in_stall is low. The depth is set by the chain of
// reciprocal multiplies: day split, time-of-day split and the calendar steps.
// Reset clears only the valid bits of the eleven stages; data is not reset.
// The pipeline moves as a whole: while a result waits under out_stall, every
// stage holds, in_stall is raised, and nothing is lost or repeated.
module epoch_seconds_to_utc_date
    import esud_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] epoch_seconds,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         second,
    output logic [5:0]         minute,
    output logic [4:0]         hour,
    output logic [4:0]         day_of_month,
    output logic [3:0]         month_index,
    output logic [7:0]         years_since_1900,
    output logic [2:0]         weekday,
    output logic [8:0]         day_of_year
);

    logic               en;
    logic [STAGES-1:0]  vld_reg, vld_next;

    // The stages advance together unless a finished result is being held.
    assign en       = !(vld_reg[STAGES-1] && out_stall);
    assign in_stall = !en;
    assign vld_next = {vld_reg[STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: biased count of 128-second units; the low 7 bits pass as they are.
    logic [25:0] x1_reg, x1_next;
    logic [6:0]  lo1_reg;

    assign x1_next = {epoch_seconds[31], epoch_seconds[31:7]} + DAY_X_BIAS;

    // Stage 2: day estimate by reciprocal of 675, which may be one low.
    logic [25:0] x2_reg;
    logic [6:0]  lo2_reg;
    logic [15:0] q2_reg, q2_next;
    logic [52:0] day_prod;

    always_comb
    begin
        day_prod = 53'(x1_reg) * 53'(RECIP_675);
        q2_next  = day_prod[51:36];
    end

    // Stage 3: remainder of the estimate, below twice 675.
    logic [15:0] q3_reg;
    logic [6:0]  lo3_reg;
    logic [10:0] r3_reg, r3_next;
    logic [25:0] q_times;
    logic [25:0] r_full;

    always_comb
    begin
        q_times = 26'(q2_reg) * 26'(675);
        r_full  = x2_reg - q_times;
        r3_next = r_full[10:0];
    end

    // Stage 4: one correction step gives the biased day count and second of day.
    logic [15:0] days4_reg, days4_next;
    logic [16:0] sod4_reg, sod4_next;
    logic [10:0] r_fix;

    always_comb
    begin
        if (r3_reg >= DAY_REM_LIMIT)
        begin
            days4_next = q3_reg + 16'd1;
            r_fix      = r3_reg - DAY_REM_LIMIT;
        end
        else
        begin
            days4_next = q3_reg;
            r_fix      = r3_reg;
        end
        sod4_next = {r_fix[9:0], lo3_reg};
    end

    // Stage 5: minute of day, and the weekday quotient. The day bias is
    // 6 modulo 7, so the weekday is (biased days + 5) modulo 7.
    logic [16:0] sod5_reg;
    logic [10:0] mod5_reg, mod5_next;
    logic [15:0] wy5_reg, wy5_next;
    logic [12:0] wq5_reg, wq5_next;
    logic [35:0] mod_prod;
    logic [32:0] wk_prod;

    always_comb
    begin
        mod_prod  = 36'(sod4_reg) * 36'(RECIP_60);
        mod5_next = mod_prod[34:24];
        wy5_next  = days4_reg + 16'd5;
        wk_prod   = 33'(wy5_next) * 33'(RECIP_7);
        wq5_next  = wk_prod[31:19];
    end

    // Stage 6: seconds, hour and weekday.
    logic [10:0] mod6_reg;
    logic [5:0]  sec6_reg, sec6_next;
    logic [4:0]  hr6_reg, hr6_next;
    logic [2:0]  wd6_reg, wd6_next;
    logic [16:0] sec_full;
    logic [29:0] hr_prod;
    logic [15:0] wd_full;

    always_comb
    begin
        sec_full  = sod5_reg - 17'(mod5_reg) * 17'd60;
        sec6_next = sec_full[5:0];
        hr_prod   = 30'(mod5_reg) * 30'(RECIP_60);
        hr6_next  = hr_prod[28:24];
        wd_full   = wy5_reg - 16'(wq5_reg) * 16'd7;
        wd6_next  = wd_full[2:0];
    end

    // Stage 7: minutes; stages 8 to 11 only delay the clock fields.
    clock_time_t time7_reg, time7_next;
    clock_time_t time_dly_reg [STAGES-CIVIL_LAT];
    logic [10:0] min_full;

    always_comb
    begin
        min_full           = mod6_reg - 11'(hr6_reg) * 11'd60;
        time7_next.second  = sec6_reg;
        time7_next.minute  = min_full[5:0];
        time7_next.hour    = hr6_reg;
        time7_next.weekday = wd6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= x1_next;
            lo1_reg   <= epoch_seconds[6:0];

            x2_reg    <= x1_reg;
            lo2_reg   <= lo1_reg;
            q2_reg    <= q2_next;

            q3_reg    <= q2_reg;
            lo3_reg   <= lo2_reg;
            r3_reg    <= r3_next;

            days4_reg <= days4_next;
            sod4_reg  <= sod4_next;

            sod5_reg  <= sod4_reg;
            mod5_reg  <= mod5_next;
            wy5_reg   <= wy5_next;
            wq5_reg   <= wq5_next;

            mod6_reg  <= mod5_reg;
            sec6_reg  <= sec6_next;
            hr6_reg   <= hr6_next;
            wd6_reg   <= wd6_next;

            time7_reg <= time7_next;

            time_dly_reg[0] <= time7_reg;
            for (int i = 1; i < STAGES - CIVIL_LAT; i++)
            begin
                time_dly_reg[i] <= time_dly_reg[i-1];
            end
        end
    end

    // Calendar part, fed with the biased day count from stage 4.
    civil_date_t date;

    esud_civil u_civil
    (
        .clk         (clk),
        .en          (en),
        .days_biased (days4_reg),
        .date        (date)
    );

    assign out_valid        = vld_reg[STAGES-1];
    assign second           = time_dly_reg[STAGES-CIVIL_LAT-1].second;
    assign minute           = time_dly_reg[STAGES-CIVIL_LAT-1].minute;
    assign hour             = time_dly_reg[STAGES-CIVIL_LAT-1].hour;
    assign weekday          = time_dly_reg[STAGES-CIVIL_LAT-1].weekday;
    assign day_of_month     = date.day_of_month;
    assign month_index      = date.month_index;
    assign years_since_1900 = date.years_since_1900;
    assign day_of_year      = date.day_of_year;

    // The clock fields, weekday and month index lie in their ranges, and the day of month is not zero.
    a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24)
                      && (weekday < 3'd7) && (month_index < 4'd12)
                      && (day_of_month != 5'd0))
        else $error("result field out of range");

    // In January the day of year follows the day of month.
    a_january_yday: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (month_index == MONTH_JANUARY)
        |-> day_of_year == 9'(day_of_month) - 9'd1)
        else $error("January day of year mismatch");

    // The first day of the year is always January 1.
    a_new_year: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (day_of_year == 9'd0)
        |-> (month_index == MONTH_JANUARY) && (day_of_month == 5'd1))
        else $error("day of year zero is not January 1");

    // When the pipeline moves, the result valid comes from the stage before it.
    a_valid_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |=> out_valid == $past(vld_reg[STAGES-2]))
        else $error("valid bit lost or invented in pipeline");

endmodule

// ===== hw/rtl/esud_civil.sv =====
// Seven-stage pipeline from a biased day count to month, day, year and day of year.
// Depends on esud_pkg.
module esud_civil
    import esud_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [15:0]       days_biased,
    output civil_date_t       date
);

    // Stage 1: pick the 400-year cycle and the day within it.
    logic        era2000_reg, era2000_next;
    logic [17:0] doe1_reg, doe1_next;

    // Stage 2: quotients needed for the year-of-cycle estimate.
    logic        era2_reg;
    logic [17:0] doe2_reg;
    logic [6:0]  quad2_reg, quad2_next;
    logic [2:0]  cent2_reg, cent2_next;
    logic        last2_reg, last2_next;
    logic [35:0] quad_prod;

    // Stage 3: day count with leap days removed.
    logic        era3_reg;
    logic [17:0] doe3_reg;
    logic [17:0] adj3_reg, adj3_next;

    // Stage 4: year within the cycle.
    logic        era4_reg;
    logic [17:0] doe4_reg;
    logic [8:0]  yoe4_reg, yoe4_next;
    logic [36:0] yoe_prod;

    // Stage 5: day within the March-based year and the leap flag.
    logic        era5_reg;
    logic [8:0]  yoe5_reg;
    logic [8:0]  doy5_reg, doy5_next;
    logic        leap5_reg, leap5_next;
    logic [1:0]  cent_yoe;
    logic [17:0] year_days;
    logic [17:0] doy_full;
    logic [8:0]  yoe_rem;

    // Stage 6: month position counted from March.
    logic        era6_reg;
    logic [8:0]  yoe6_reg;
    logic [8:0]  doy6_reg;
    logic        leap6_reg;
    logic [3:0]  mp6_reg, mp6_next;
    logic [10:0] mp_num;
    logic [23:0] mp_prod;

    // Stage 7: final fields.
    civil_date_t date_reg, date_next;
    logic [3:0]  mi7;
    logic [8:0]  day_in_month;
    logic [9:0]  year_sum;

    always_comb
    begin
        era2000_next = (days_biased >= ERA_2000_DAY);
        if (era2000_next)
        begin
            doe1_next = 18'(days_biased) - ERA_2000_OFFSET;
        end
        else
        begin
            doe1_next = 18'(days_biased) + ERA_1600_OFFSET;
        end
    end

    always_comb
    begin
        quad_prod  = 36'(doe1_reg) * 36'(RECIP_1460);
        quad2_next = quad_prod[34:28];
        cent2_next = 3'(doe1_reg >= CENTURY_1_DAYS) + 3'(doe1_reg >= CENTURY_2_DAYS)
                   + 3'(doe1_reg >= CENTURY_3_DAYS) + 3'(doe1_reg >= LAST_CYCLE_DAY);
        last2_next = (doe1_reg == LAST_CYCLE_DAY);
    end

    assign adj3_next = doe2_reg - 18'(quad2_reg) + 18'(cent2_reg) - 18'(last2_reg);

    always_comb
    begin
        yoe_prod  = 37'(adj3_reg) * 37'(RECIP_365);
        yoe4_next = yoe_prod[35:27];
    end

    always_comb
    begin
        cent_yoe   = 2'(yoe4_reg >= 9'd100) + 2'(yoe4_reg >= 9'd200)
                   + 2'(yoe4_reg >= 9'd300);
        year_days  = 18'(yoe4_reg) * 18'd365 + 18'(yoe4_reg[8:2]) - 18'(cent_yoe);
        doy_full   = doe4_reg - year_days;
        doy5_next  = doy_full[8:0];
        yoe_rem    = yoe4_reg - 9'(cent_yoe) * 9'd100;
        leap5_next = (yoe4_reg[1:0] == 2'd0) && ((yoe_rem != 9'd0) || (yoe4_reg == 9'd0));
    end

    always_comb
    begin
        mp_num   = 11'(doy5_reg) * 11'd5 + 11'd2;
        mp_prod  = 24'(mp_num) * 24'(RECIP_153);
        mp6_next = mp_prod[23:20];
    end

    // Months from March on belong to the cycle year; January and February to the next.
    always_comb
    begin
        if (mp6_reg < MONTH_MARCH_POS_LIMIT)
        begin
            mi7 = mp6_reg + 4'd2;
        end
        else
        begin
            mi7 = mp6_reg - MONTH_MARCH_POS_LIMIT;
        end
        day_in_month = doy6_reg - MARCH_MONTH_START[mp6_reg];
        year_sum     = 10'(yoe6_reg) + (era6_reg ? 10'd100 : 10'd724)
                     + 10'(mp6_reg >= MONTH_MARCH_POS_LIMIT);
        date_next.month_index      = mi7;
        date_next.day_of_month     = 5'(day_in_month) + 5'd1;
        date_next.years_since_1900 = year_sum[7:0];
        date_next.day_of_year      = DAYS_BEFORE_MONTH[mi7] + day_in_month
                                   + 9'((mp6_reg < MONTH_MARCH_POS_LIMIT) && leap6_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            era2000_reg <= era2000_next;
            doe1_reg    <= doe1_next;

            era2_reg    <= era2000_reg;
            doe2_reg    <= doe1_reg;
            quad2_reg   <= quad2_next;
            cent2_reg   <= cent2_next;
            last2_reg   <= last2_next;

            era3_reg    <= era2_reg;
            doe3_reg    <= doe2_reg;
            adj3_reg    <= adj3_next;

            era4_reg    <= era3_reg;
            doe4_reg    <= doe3_reg;
            yoe4_reg    <= yoe4_next;

            era5_reg    <= era4_reg;
            yoe5_reg    <= yoe4_reg;
            doy5_reg    <= doy5_next;
            leap5_reg   <= leap5_next;

            era6_reg    <= era5_reg;
            yoe6_reg    <= yoe5_reg;
            doy6_reg    <= doy5_reg;
            leap6_reg   <= leap5_reg;
            mp6_reg     <= mp6_next;

            date_reg    <= date_next;
        end
    end

    assign date = date_reg;

endmodule
